[src/cic_pkg.sv]
`timescale 1ns / 1ps
// Package for the cloud-in-cell deposit grid: item modes and register indexes.
// No dependencies; imported by the top level.
package cic_pkg;

    // item kinds carried on the slave tuser
    localparam logic [1:0] MODE_DEPOSIT = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // result status carried on the master tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OUT_BOX   = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_CELLS    = 3'd0;
    localparam logic [2:0] CFG_SCALE    = 3'd1;
    localparam logic [2:0] CFG_BOX      = 3'd2;
    localparam logic [2:0] CFG_WEIGHTS  = 3'd3;
    localparam logic [2:0] CFG_DENSITY  = 3'd4;

    localparam int CELL_W = 40;
    localparam int DENS_W = 48;

    typedef logic [CELL_W-1:0] t_cell;

endpackage

[src/cic_mass_deposit_periodic_grid.sv]
`timescale 1ns / 1ps
// Deposit: scaling steps, then eight corner read-modify-writes; read: stops early when the
// index is out of range; clear: sweeps the grid; out-of-box or unused mode: no grid access.
// One word at a time: every product goes through the single shared multiplier and
// every cell update through the one read-modify-write port of the grid memory; the
// next word is accepted in the cycle after the result is registered.
// Synchronous active-low reset; after reset all GRID_MAX**3 cells of the grid memory
// (262144 at the default) are swept to zero before the first word is accepted.
module cic_mass_deposit_periodic_grid
    import cic_pkg::*;
#(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // x_pos[31:0], y_pos[63:32], z_pos[95:64], mass[119:96],
    // cell_index[137:120], zero fill [143:138]
    input  logic [143:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // density[47:0]
    output logic [47:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    localparam int BW    = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int PW    = CELL_W + BW;
    localparam int STORE = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(STORE);
    localparam int IW    = $clog2(GRID_MAX);
    localparam int NW    = IW + 1;
    localparam int FW    = FRAC_BITS;
    localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEP  = 3'd2;
    localparam logic [2:0] S_WXY  = 3'd3;
    localparam logic [2:0] S_SH   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // configuration
    logic [6:0]  r_cfg_cells;
    logic [31:0] r_cfg_scale, r_cfg_box, r_cfg_dens;
    logic        r_cfg_wts;

    // control
    logic [2:0]  r_state, n_state;
    logic [3:0]  r_step;
    logic [2:0]  r_corner;
    logic [AW-1:0] r_clr;
    logic        r_clr_item;

    // item and working values
    logic [31:0] r_px, r_py, r_pz;
    logic [23:0] r_w;
    logic [17:0] r_idx;
    logic [47:0] r_acc;
    logic [IW-1:0] r_ix, r_iy, r_iz;
    logic [FW-1:0] r_tx, r_ty, r_tz;
    logic [23:0] r_mz0, r_mz1;
    logic [AW-1:0] r_x0, r_x1, r_y0, r_y1, r_addr;
    logic [FW:0] r_wxy;
    t_cell       r_cw;
    logic [PW-1:0] r_prod;

    // result
    logic [47:0] r_dens, r_out_dens;
    logic [1:0]  r_status, r_out_status;
    logic        r_out_valid;

    // memory
    t_cell       r_mem [STORE];
    t_cell       r_rdata;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        wr_en;
    t_cell       wr_data;

    logic [39:0]   mul_a;
    logic [BW-1:0] mul_b;
    logic [NW-1:0] n_eff;
    logic [IW-1:0] ix1, iy1, iz1;
    logic [63:0]   c64;
    logic [31:0]   raw;
    logic [IW-1:0] cell_pos;
    logic [FW-1:0] frac;
    logic [FW:0]   wx_a, wy_b;
    logic [AW-1:0] corner_addr;
    logic [40:0]   sat_sum;
    logic [56:0]   dens_sum;
    logic          in_acc, box_bad, out_free;
    logic [31:0]   in_x, in_y, in_z;

    assign in_x = s_axis_tdata[31:0];
    assign in_y = s_axis_tdata[63:32];
    assign in_z = s_axis_tdata[95:64];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign box_bad = (in_x >= r_cfg_box) || (in_y >= r_cfg_box) || (in_z >= r_cfg_box);
    assign out_free = !r_out_valid || m_axis_tready;

    // effective cells per axis: 0 acts as 1, clamp to built size
    always_comb begin
        if (r_cfg_cells == 7'd0) begin
            n_eff = NW'(1);
        end else if (32'(r_cfg_cells) > 32'(GRID_MAX)) begin
            n_eff = NW'(GRID_MAX);
        end else begin
            n_eff = NW'(r_cfg_cells);
        end
    end

    // periodic +1 neighbors
    assign ix1 = (NW'(r_ix) + NW'(1) >= n_eff) ? '0 : r_ix + IW'(1);
    assign iy1 = (NW'(r_iy) + NW'(1) >= n_eff) ? '0 : r_iy + IW'(1);
    assign iz1 = (NW'(r_iz) + NW'(1) >= n_eff) ? '0 : r_iz + IW'(1);

    // combine the two partial products of one scaled axis
    assign c64  = {16'b0, r_acc} + {r_prod[47:0], 16'b0};
    assign raw  = c64[63:32];
    assign cell_pos = (raw >= 32'(n_eff)) ? '0 : raw[IW-1:0];
    assign frac = c64[31:32-FW];

    assign wx_a = r_corner[2] ? {1'b0, r_tx} : ONE - {1'b0, r_tx};
    assign wy_b = r_corner[1] ? {1'b0, r_ty} : ONE - {1'b0, r_ty};
    assign corner_addr = (r_corner[2] ? r_x1 : r_x0) + (r_corner[1] ? r_y1 : r_y0)
                       + AW'(r_corner[0] ? iz1 : r_iz);

    assign sat_sum  = {1'b0, r_rdata} + 41'(r_prod[PW-1:FW]);
    assign dens_sum = {1'b0, r_prod[55:0]} + 57'(r_acc);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_DEP: begin
                unique case (r_step)
                    4'd0:  begin mul_a = 40'(r_px); mul_b = BW'(r_cfg_scale[15:0]);  end
                    4'd1:  begin mul_a = 40'(r_px); mul_b = BW'(r_cfg_scale[31:16]); end
                    4'd2:  begin mul_a = 40'(r_py); mul_b = BW'(r_cfg_scale[15:0]);  end
                    4'd3:  begin mul_a = 40'(r_py); mul_b = BW'(r_cfg_scale[31:16]); end
                    4'd4:  begin mul_a = 40'(r_pz); mul_b = BW'(r_cfg_scale[15:0]);  end
                    4'd5:  begin mul_a = 40'(r_pz); mul_b = BW'(r_cfg_scale[31:16]); end
                    4'd7:  begin mul_a = 40'(r_w); mul_b = BW'(ONE - {1'b0, r_tz}); end
                    4'd8:  begin mul_a = 40'(r_w); mul_b = BW'(r_tz); end
                    4'd9:  begin mul_a = 40'(r_ix); mul_b = BW'(n_eff); end
                    4'd10: begin mul_a = r_prod[39:0]; mul_b = BW'(n_eff); end
                    4'd11: begin mul_a = 40'(ix1); mul_b = BW'(n_eff); end
                    4'd12: begin mul_a = r_prod[39:0]; mul_b = BW'(n_eff); end
                    4'd13: begin mul_a = 40'(r_iy); mul_b = BW'(n_eff); end
                    4'd14: begin mul_a = 40'(iy1); mul_b = BW'(n_eff); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_WXY: begin
                mul_a = 40'(wx_a);
                mul_b = BW'(wy_b);
            end
            S_SH: begin
                mul_a = 40'(r_corner[0] ? r_mz1 : r_mz0);
                mul_b = r_corner[0] ? BW'(r_wxy) : BW'(r_prod[2*FW:FW]);
            end
            S_RD: begin
                unique case (r_step)
                    4'd0:    begin mul_a = 40'(n_eff); mul_b = BW'(n_eff); end
                    4'd1:    begin mul_a = r_prod[39:0]; mul_b = BW'(n_eff); end
                    4'd3:    begin mul_a = r_rdata; mul_b = BW'(r_cfg_dens[15:0]); end
                    4'd4:    begin mul_a = r_cw; mul_b = BW'(r_cfg_dens[31:16]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory port select
    always_comb begin
        rd_addr = (r_state == S_RD) ? AW'(r_idx) : corner_addr;
        wr_en   = (r_state == S_CLR) || (r_state == S_WR);
        wr_addr = (r_state == S_CLR) ? r_clr : r_addr;
        wr_data = (r_state == S_CLR) ? '0 : (sat_sum[40] ? '1 : sat_sum[39:0]);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == AW'(STORE - 1)) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        MODE_DEPOSIT: n_state = box_bad ? S_DONE : S_DEP;
                        MODE_READ:    n_state = S_RD;
                        MODE_CLEAR:   n_state = S_CLR;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_DEP:  n_state = (r_step == 4'd15) ? S_WXY : S_DEP;
            S_WXY:  n_state = S_SH;
            S_SH:   n_state = S_WR;
            S_WR: begin
                priority if (r_corner == 3'd7) begin
                    n_state = S_DONE;
                end else if (!r_corner[0]) begin
                    n_state = S_SH;
                end else begin
                    n_state = S_WXY;
                end
            end
            S_RD: begin
                priority if (r_step == 4'd2 && 64'(r_idx) >= 64'(r_prod)) begin
                    n_state = S_DONE;
                end else if (r_step == 4'd5) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // grid memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_step      <= '0;
            r_corner    <= '0;
            r_clr       <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_cells <= 7'd64;
            r_cfg_scale <= 32'd65536;
            r_cfg_box   <= 32'd4194304;
            r_cfg_wts   <= 1'b0;
            r_cfg_dens  <= 32'd65536;
        end else begin
            r_state <= n_state;
            // take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CELLS:   r_cfg_cells <= i_cfg_data[6:0];
                    CFG_SCALE:   r_cfg_scale <= i_cfg_data;
                    CFG_BOX:     r_cfg_box   <= i_cfg_data;
                    CFG_WEIGHTS: r_cfg_wts   <= i_cfg_data[0];
                    CFG_DENSITY: r_cfg_dens  <= i_cfg_data;
                    default: ;
                endcase
            end
            // advance step and corner counters
            if (r_state != n_state) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 4'd1;
            end
            if (r_state == S_IDLE) begin
                r_corner <= '0;
            end else if (r_state == S_WR) begin
                r_corner <= r_corner + 3'd1;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end
            if (in_acc) begin
                r_clr_item <= (s_axis_tuser == MODE_CLEAR);
            end
            // hold the result until the master side takes it
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (in_acc) begin
            r_px     <= in_x;
            r_py     <= in_y;
            r_pz     <= in_z;
            r_w      <= r_cfg_wts ? s_axis_tdata[119:96] : 24'h010000;
            r_idx    <= s_axis_tdata[137:120];
            r_dens   <= '0;
            r_status <= (s_axis_tuser == MODE_DEPOSIT && box_bad) ? ST_OUT_BOX : ST_OK;
        end
        if (r_state == S_DEP) begin
            unique case (r_step)
                4'd1, 4'd3, 4'd5: r_acc <= r_prod[47:0];
                4'd2: begin r_ix <= cell_pos; r_tx <= frac; end
                4'd4: begin r_iy <= cell_pos; r_ty <= frac; end
                4'd6: begin r_iz <= cell_pos; r_tz <= frac; end
                4'd8:  r_mz0 <= r_prod[FW+23:FW];
                4'd9:  r_mz1 <= r_prod[FW+23:FW];
                4'd11: r_x0 <= r_prod[AW-1:0];
                4'd13: r_x1 <= r_prod[AW-1:0];
                4'd14: r_y0 <= r_prod[AW-1:0];
                4'd15: r_y1 <= r_prod[AW-1:0];
                default: ;
            endcase
        end
        // latch corner product and address for the update
        if (r_state == S_SH) begin
            r_addr <= corner_addr;
            if (!r_corner[0]) begin
                r_wxy <= r_prod[2*FW:FW];
            end
        end
        if (r_state == S_RD) begin
            unique case (r_step)
                4'd2: if (64'(r_idx) >= 64'(r_prod)) r_status <= ST_BAD_INDEX;
                4'd3: r_cw <= r_rdata;
                4'd4: r_acc <= 48'(r_prod[PW-1:16]);
                4'd5: r_dens <= (dens_sum[56:48] != '0) ? '1 : dens_sum[47:0];
                default: ;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out_dens   <= r_dens;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_dens;
    assign m_axis_tuser  = r_out_status;

endmodule

[src/cic_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the cloud-in-cell deposit grid, and the bind to the top level.
// Depends on cic_pkg and cic_mass_deposit_periodic_grid.
module cic_checker
    import cic_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while busy");

    // only the defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_OUT_BOX
                           || m_axis_tuser == ST_BAD_INDEX))
        else $error("undefined status");

    // an error result carries no density
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero density on error");

endmodule

bind cic_mass_deposit_periodic_grid cic_checker u_cic_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_cic_mass_deposit_periodic_grid.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cic_mass_deposit_periodic_grid: drives deposit, read,
// clear and unused words through the streams and checks each result word.
// Depends on cic_pkg and the block under test only.
module tb_cic_mass_deposit_periodic_grid;
    import cic_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint unsigned STORE_SAT = (64'd1 << 40) - 1;
    localparam longint unsigned DENS_SAT  = (64'd1 << 48) - 1;
    localparam longint unsigned UNIT      = 64'd1 << 16;
    localparam int HOLD_CYCLES = 400;

    // Predicts every result word from a private copy of the grid and the registers
    class grid_scoreboard;
        longint unsigned cell_sum[int];
        logic [6:0]  cells_reg;
        logic [31:0] scale_reg;
        logic [31:0] box_reg;
        logic        weights_reg;
        logic [31:0] dens_reg;
        logic [47:0] dens_q[$];
        logic [1:0]  status_q[$];
        int errors;
        int last_cell;

        function new();
            cells_reg = 7'd64;
            scale_reg = 32'd65536;
            box_reg = 32'd4194304;
            weights_reg = 1'b0;
            dens_reg = 32'd65536;
            errors = 0;
            last_cell = 0;
        endfunction

        function int axis_count();
            if (cells_reg == 0) return 1;
            if (cells_reg > 64) return 64;
            return int'(cells_reg);
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] value);
            case (addr)
                CFG_CELLS:   cells_reg = value[6:0];
                CFG_SCALE:   scale_reg = value;
                CFG_BOX:     box_reg = value;
                CFG_WEIGHTS: weights_reg = value[0];
                CFG_DENSITY: dens_reg = value;
                default: ;
            endcase
        endfunction

        // split a position into its cell along one axis and its Q0.16 offset
        function void split_pos(logic [31:0] pos, int n, output int axis_cell,
                                output longint unsigned frac);
            longint unsigned prod;
            prod = longint'(pos) * longint'(scale_reg);
            axis_cell = (prod[63:32] >= n) ? 0 : int'(prod[63:32]);
            frac = 64'(prod[31:16]);
        endfunction

        function void add_share(int idx, longint unsigned share);
            longint unsigned sum;
            sum = (cell_sum.exists(idx) ? cell_sum[idx] : 64'd0) + share;
            cell_sum[idx] = (sum > STORE_SAT) ? STORE_SAT : sum;
        endfunction

        function logic [1:0] deposit(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [23:0] w);
            int n, cx[2], cy[2], cz[2];
            longint unsigned tx, ty, tz, wt, wx[2], wy[2], mz[2], wxy;
            n = axis_count();
            if (x >= box_reg || y >= box_reg || z >= box_reg) return ST_OUT_BOX;
            split_pos(x, n, cx[0], tx);
            split_pos(y, n, cy[0], ty);
            split_pos(z, n, cz[0], tz);
            cx[1] = (cx[0] + 1 >= n) ? 0 : cx[0] + 1;
            cy[1] = (cy[0] + 1 >= n) ? 0 : cy[0] + 1;
            cz[1] = (cz[0] + 1 >= n) ? 0 : cz[0] + 1;
            wt = weights_reg ? 64'(w) : UNIT;
            wx[0] = UNIT - tx; wx[1] = tx;
            wy[0] = UNIT - ty; wy[1] = ty;
            mz[0] = (wt * (UNIT - tz)) >> 16;
            mz[1] = (wt * tz) >> 16;
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++) begin
                    wxy = (wx[a] * wy[b]) >> 16;
                    for (int c = 0; c < 2; c++)
                        add_share((cx[a] * n + cy[b]) * n + cz[c], (wxy * mz[c]) >> 16);
                end
            last_cell = (cx[0] * n + cy[0]) * n + cz[0];
            return ST_OK;
        endfunction

        // note an accepted input word and queue its expected result
        function void note_input(logic [1:0] mode, logic [143:0] data);
            logic [47:0] dens;
            logic [1:0] st;
            longint unsigned cw, r;
            int n, idx;
            dens = '0;
            st = ST_OK;
            case (mode)
                MODE_DEPOSIT: st = deposit(data[31:0], data[63:32], data[95:64],
                                           data[119:96]);
                MODE_READ: begin
                    n = axis_count();
                    idx = int'(data[137:120]);
                    if (idx >= n * n * n) begin
                        st = ST_BAD_INDEX;
                    end else begin
                        cw = cell_sum.exists(idx) ? cell_sum[idx] : 64'd0;
                        r = cw * longint'(dens_reg[31:16]) +
                            ((cw * longint'(dens_reg[15:0])) >> 16);
                        dens = (r > DENS_SAT) ? DENS_SAT[47:0] : r[47:0];
                    end
                end
                MODE_CLEAR: cell_sum.delete();
                default: ;
            endcase
            dens_q.push_back(dens);
            status_q.push_back(st);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(logic [47:0] dens, logic [1:0] st);
            logic [47:0] exp_d;
            logic [1:0] exp_s;
            if (dens_q.size() == 0) begin
                report($sformatf("unexpected word density=%0h status=%0d", dens, st));
            end else begin
                exp_d = dens_q.pop_front();
                exp_s = status_q.pop_front();
                if (dens !== exp_d)
                    report($sformatf("density %0h, want %0h", dens, exp_d));
                if (st !== exp_s)
                    report($sformatf("status %0d, want %0d", st, exp_s));
            end
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    grid_scoreboard sb = new();
    int send_idle = 0;
    int rx_stall = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    cic_mass_deposit_periodic_grid uut (.*);

    always #5 i_clk = ~i_clk;

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall);
        end
    end

    // check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(addr, value);
    endtask

    task setup(logic [6:0] cells, logic [31:0] scale, logic [31:0] box, logic weights,
               logic [31:0] dscale);
        write_reg(CFG_CELLS, {25'd0, cells});
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_BOX, box);
        write_reg(CFG_WEIGHTS, {31'd0, weights});
        write_reg(CFG_DENSITY, dscale);
    endtask

    // offer one word, idling first at random, and hold it until accepted
    task send_word(logic [1:0] mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                   logic [23:0] w, logic [17:0] idx);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {6'd0, idx, w, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(mode, {6'd0, idx, w, z, y, x});
    endtask

    // drop valid and wait until every result is back, plus a settling margin
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.dens_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function logic [31:0] rand_pos();
        if ($urandom_range(99) < 85)
            return $urandom_range(sb.box_reg - 1, 0);
        return $urandom();
    endfunction

    task random_words(int count, int with_clear);
        int pick, n;
        logic [17:0] idx;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            n = sb.axis_count();
            if (with_clear && i == count / 2) begin
                send_word(MODE_CLEAR, $urandom(), $urandom(), $urandom(),
                          24'($urandom()), 18'($urandom()));
            end else if (pick < 60) begin
                send_word(MODE_DEPOSIT, rand_pos(), rand_pos(), rand_pos(),
                          24'($urandom()), 18'($urandom()));
            end else if (pick < 92) begin
                pick = $urandom_range(99);
                if (pick < 65) idx = 18'(sb.last_cell);
                else if (pick < 90) idx = 18'($urandom_range(n * n * n - 1, 0));
                else idx = 18'($urandom());
                send_word(MODE_READ, $urandom(), $urandom(), $urandom(),
                          24'($urandom()), idx);
            end else begin
                send_word(MODE_UNUSED, $urandom(), $urandom(), $urandom(),
                          24'($urandom()), 18'($urandom()));
            end
        end
        drain();
    endtask

    // stop a hung run
    initial begin
        #(60_000_000);
        $display("tb_cic_mass_deposit_periodic_grid: errors");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset settings
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd0);
        send_word(MODE_DEPOSIT, 0, 0, 0, 24'hFFFFFF, 18'd0);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd0);
        send_word(MODE_DEPOSIT, 32'h003FFFFF, 32'h003FFFFF, 32'h003FFFFF, 24'd0, 18'd0);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'h3FFFF);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd4096);
        send_word(MODE_DEPOSIT, 32'h00400000, 0, 0, 24'd0, 18'd0);
        send_word(MODE_DEPOSIT, 0, 0, 32'hFFFFFFFF, 24'd0, 18'd0);
        send_word(MODE_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
                  18'h3FFFF);
        send_word(MODE_CLEAR, 0, 0, 0, 24'd0, 18'd0);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd0);
        drain();

        // single cell, weights in use, largest density scale
        setup(7'd1, 32'h00018000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
        send_word(MODE_DEPOSIT, 32'h00012345, 32'h0000ABCD, 32'hFFFFFFFE, 24'hFFFFFF,
                  18'd0);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd0);
        send_word(MODE_READ, 0, 0, 0, 24'd0, 18'd1);
        drain();

        // phase: small grid, no idling
        setup(7'd4, 32'h00010000, 32'h00040000, 1'b1, 32'h00010000);
        random_words(150, 0);

        // phase: one cell, sender idles
        send_idle = 60; rx_stall = 0;
        setup(7'd1, 32'h00008000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
        random_words(150, 0);

        // phase: zero cells acts as one, largest scale, receiver stalls
        send_idle = 0; rx_stall = 60;
        setup(7'd0, 32'hFFFFFFFF, 32'h00020000, 1'b0, 32'h00000001);
        random_words(150, 0);

        // phase: oversize cell count, both idle, long receiver hold-off
        send_idle = 33; rx_stall = 33;
        setup(7'd127, 32'h00020000, 32'h00400000, 1'b1, 32'h00028000);
        hold_req <= ~hold_req;
        random_words(150, 0);

        // phase: five cells with a clear in the middle, zero density scale
        setup(7'd5, 32'h00014000, 32'h00050000, 1'b1, 32'h00000000);
        random_words(150, 1);

        // phase: no idling, two cells, weights off
        send_idle = 0; rx_stall = 0;
        setup(7'd2, 32'h00010000, 32'h00020000, 1'b0, 32'h00010000);
        random_words(100, 0);

        // phase: zero scale and the smallest box
        setup(7'd64, 32'h00000000, 32'h00000001, 1'b0, 32'h00010000);
        random_words(60, 0);

        if (sb.errors == 0)
            $display("tb_cic_mass_deposit_periodic_grid: clean");
        else
            $display("tb_cic_mass_deposit_periodic_grid: errors");
        $finish;
    end
endmodule

[cic_mass_deposit_periodic_grid.f]
src/cic_pkg.sv
src/cic_mass_deposit_periodic_grid.sv
src/cic_checker.sv
tb/tb_cic_mass_deposit_periodic_grid.sv
